// ===== src/ssi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and codes for the sorted set block
// Request/response payloads, cell control and neighbor link types.
// ----------------------------------------------------------------------------
package ssi_pkg;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // response status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int TOTAL_W = 5;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] item_value;
    } ssi_req_t;

    typedef struct packed {
        logic               hit;
        logic [1:0]         status;
        logic [TOTAL_W-1:0] entry_total;
    } ssi_rsp_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;    // latch compare flags
        logic shift_en;  // commit insert
        logic occupied;  // cell index below entry count
        logic at_end;    // cell index equals entry count
    } ssi_cell_ctl_t;

    // value handed to the next cell up
    typedef struct packed {
        logic signed [31:0] value;
        logic               mov;     // this cell moves up on insert
    } ssi_link_t;

endpackage

// ===== src/ssi_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_cell: one storage cell of the sorted chain
// Holds one entry, compares it against the key and shifts up on insert.
// ----------------------------------------------------------------------------
module ssi_cell
    import ssi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ssi_cell_ctl_t      ctl,
    input  logic signed [31:0] key,
    input  ssi_link_t          link_in,
    output ssi_link_t          link_out,
    output logic               eq
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               eq_reg;
    logic               gt_reg;
    logic               mov;

    // cells above the insert point move up, the cell at the point takes the key
    assign mov = gt_reg | ctl.at_end;

    always_comb
    begin
        if (link_in.mov)
        begin
            value_next = link_in.value;
        end
        else if (mov)
        begin
            value_next = key;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.shift_en)
        begin
            value_reg <= value_next;
        end
    end

    // compare flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eq_reg <= 1'b0;
            gt_reg <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            eq_reg <= ctl.occupied & (value_reg == key);
            gt_reg <= ctl.occupied & (value_reg > key);
        end
    end

    assign link_out.value = value_reg;
    assign link_out.mov   = mov;
    assign eq             = eq_reg;

endmodule

// ===== src/sorted_set_insert_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_insert_lookup: ascending set of distinct signed 32-bit values
// Busy covers the input register cycle and the per-cell compare cycle before
// the insert/shift decision; a new start is taken only while busy is low.
// Reset: entry count cleared, set empty; entry storage is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
module sorted_set_insert_lookup
    import ssi_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  ssi_req_t req,
    output logic     done,
    output ssi_rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic               p1_valid_reg;
    logic               p2_valid_reg;
    logic               cmd_reg;
    logic signed [31:0] key_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    ssi_rsp_t           rsp_reg;
    ssi_rsp_t           rsp_next;

    logic [CAPACITY-1:0] eq_vec;
    ssi_link_t           link [CAPACITY+1];
    logic                found;
    logic                full;
    logic                insert_ok;

    // input register and stage valids
    assign busy = p1_valid_reg | p2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= start & ~busy;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= req.cmd;
            key_reg <= req.item_value;
        end
    end

    // chain of cells
    assign link[0].value = '0;
    assign link[0].mov   = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        ssi_cell_ctl_t ctl;

        assign ctl.cmp_en   = p1_valid_reg;
        assign ctl.shift_en = p2_valid_reg & insert_ok;
        assign ctl.occupied = (CNT_W'(g) < count_reg);
        assign ctl.at_end   = (CNT_W'(g) == count_reg);

        ssi_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .key      (key_reg),
            .link_in  (link[g]),
            .link_out (link[g+1]),
            .eq       (eq_vec[g])
        );
    end

    // decision
    assign found     = |eq_vec;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign insert_ok = (cmd_reg == CMD_INSERT) & ~found & ~full;
    assign count_next = insert_ok ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        rsp_next.hit         = 1'b0;
        rsp_next.status      = ST_DONE;
        rsp_next.entry_total = TOTAL_W'(count_next);
        if (cmd_reg == CMD_QUERY)
        begin
            rsp_next.hit = found;
        end
        else if (found)
        begin
            rsp_next.status = ST_DUP;
        end
        else if (full)
        begin
            rsp_next.status = ST_FULL;
        end
        else
        begin
            rsp_next.hit = 1'b1;
        end
    end

    // count and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= p2_valid_reg;
            if (p2_valid_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    // a result only follows a decision cycle
    a_done_after_decide : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(p2_valid_reg))
        else $error("done without a decision cycle");

    // count never passes capacity
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a full refusal leaves the set full
    a_full_refusal : assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_FULL |-> count_reg == CNT_W'(CAPACITY))
        else $error("full refusal with room left");

    // count moves only on a successful insert
    a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg && !insert_ok |=> $stable(count_reg))
        else $error("count changed without insert");
`endif

endmodule
